FILE: hw/rtl/pfe_pkg.sv
// Shared types and constants for the postfix expression evaluator.
// Depends on nothing; every other file but pfe_ram imports it.
`timescale 1ns / 1ps

package pfe_pkg;

  localparam int CHAR_W      = 8;
  localparam int VALUE_W     = 32;
  localparam int DIGIT_W     = 4;
  localparam int STACK_DEPTH = 16;
  localparam int STACK_AW    = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int Q_DEPTH     = 2;
  localparam int Q_AW        = $clog2(Q_DEPTH);
  localparam int DIV_CNT_W   = $clog2(VALUE_W + 1);

  localparam logic [CHAR_W-1:0]  CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0]  CHAR_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0]  CHAR_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0]  DIGIT_MAX  = 8'd9;
  localparam logic [VALUE_W-1:0] EMPTY_VALUE = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef enum logic [1:0] {
    KIND_NOP  = 2'd0,
    KIND_PUSH = 2'd1,
    KIND_OP   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef struct packed {
    kind_t              kind;
    op_t                op;
    logic [DIGIT_W-1:0] digit;
    logic               last;
  } cmd_t;

endpackage

FILE: hw/rtl/pfe_in_if.sv
// Input channel: one expression character per word, with valid/ready.
// Depends on pfe_pkg for field widths.
`timescale 1ns / 1ps

interface pfe_in_if;
  import pfe_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

FILE: hw/rtl/pfe_out_if.sv
// Result channel: popped value and sticky flags, with valid/ready.
// Depends on pfe_pkg for field widths.
`timescale 1ns / 1ps

interface pfe_out_if;
  import pfe_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      underflow;
  logic                      overflow;
  logic                      div_by_zero;

  modport source (output valid, output value, output underflow, output overflow,
                  output div_by_zero, input ready);
  modport sink   (input valid, input value, input underflow, input overflow,
                  input div_by_zero, output ready);
endinterface

FILE: hw/rtl/pfe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module pfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hw/rtl/pfe_div.sv
// Iterative signed divider, truncating toward zero, one quotient bit a cycle.
// Depends on pfe_pkg. Divisor must be non-zero when started.
`timescale 1ns / 1ps

module pfe_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pfe_pkg::VALUE_W-1:0] num,
  input  logic [pfe_pkg::VALUE_W-1:0] den,
  output logic                        done,
  output logic [pfe_pkg::VALUE_W-1:0] quotient
);
  import pfe_pkg::*;

  logic                 busy;
  logic                 neg;
  logic [DIV_CNT_W-1:0] cnt;
  logic [VALUE_W-1:0]   rem;
  logic [VALUE_W-1:0]   quo;
  logic [VALUE_W-1:0]   den_r;
  logic [VALUE_W:0]     rem_sh;
  logic [VALUE_W:0]     diff;

  assign rem_sh   = {rem, quo[VALUE_W-1]};
  assign diff     = rem_sh - {1'b0, den_r};
  assign quotient = neg ? (VALUE_W'(0) - quo) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && cnt == DIV_CNT_W'(1);
      if (start) begin
        busy  <= 1'b1;
        neg   <= num[VALUE_W-1] ^ den[VALUE_W-1];
        quo   <= num[VALUE_W-1] ? (VALUE_W'(0) - num) : num;
        den_r <= den[VALUE_W-1] ? (VALUE_W'(0) - den) : den;
        rem   <= '0;
        cnt   <= DIV_CNT_W'(VALUE_W);
      end else if (busy) begin
        if (!diff[VALUE_W]) begin
          rem <= diff[VALUE_W-1:0];
          quo <= {quo[VALUE_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[VALUE_W-1:0];
          quo <= {quo[VALUE_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/pfe_front.sv
// Front end: accept characters, classify them into stack commands.
// Depends on pfe_pkg and pfe_in_if; drops ignored characters unless last.
`timescale 1ns / 1ps

module pfe_front (
  input  logic           clk,
  input  logic           rst,
  pfe_in_if.sink         feed,
  output logic           cmd_valid,
  output pfe_pkg::cmd_t  cmd_word,
  input  logic           cmd_ready
);
  import pfe_pkg::*;

  logic              hold_valid;
  cmd_t              hold_word;
  cmd_t              cls;
  logic              keep;
  logic [CHAR_W-1:0] offset;

  assign feed.ready = !hold_valid || cmd_ready;
  assign cmd_valid  = hold_valid;
  assign cmd_word   = hold_word;
  assign offset     = feed.char_code - CHAR_ZERO;

  always_comb begin
    cls.kind  = KIND_NOP;
    cls.op    = OP_ADD;
    cls.digit = offset[DIGIT_W-1:0];
    cls.last  = feed.last;
    case (feed.char_code)
      CHAR_PLUS: begin
        cls.kind = KIND_OP;
        cls.op   = OP_ADD;
      end
      CHAR_MINUS: begin
        cls.kind = KIND_OP;
        cls.op   = OP_SUB;
      end
      CHAR_STAR: begin
        cls.kind = KIND_OP;
        cls.op   = OP_MUL;
      end
      CHAR_SLASH: begin
        cls.kind = KIND_OP;
        cls.op   = OP_DIV;
      end
      default: begin
        if (feed.char_code >= CHAR_ZERO && offset <= DIGIT_MAX) begin
          cls.kind = KIND_PUSH;
        end
      end
    endcase
    keep = (cls.kind != KIND_NOP) || feed.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (feed.valid && feed.ready) begin
      hold_valid <= keep;
      hold_word  <= cls;
    end else if (cmd_ready) begin
      hold_valid <= 1'b0;
    end
  end

endmodule

FILE: hw/rtl/pfe_queue.sv
// Short command queue between front and back ends.
// Depends on pfe_pkg.
`timescale 1ns / 1ps

module pfe_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  pfe_pkg::cmd_t  in_word,
  output logic           in_ready,
  output logic           out_valid,
  output pfe_pkg::cmd_t  out_word,
  input  logic           out_ready
);
  import pfe_pkg::*;

  cmd_t            slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   fill;
  logic            push;
  logic            pop;

  assign in_ready  = fill < (Q_AW+1)'(Q_DEPTH);
  assign out_valid = fill != '0;
  assign out_word  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/pfe_back.sv
// Back end: operand stack, arithmetic, divider and result register.
// Depends on pfe_pkg, pfe_out_if, pfe_ram and pfe_div.
`timescale 1ns / 1ps

module pfe_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  pfe_pkg::cmd_t  cmd_word,
  output logic           cmd_ready,
  pfe_out_if.source      result
);
  import pfe_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_POP_R   = 8'b0000_0010,
    S_POP_L   = 8'b0000_0100,
    S_EXEC    = 8'b0000_1000,
    S_DIV     = 8'b0001_0000,
    S_PUSH    = 8'b0010_0000,
    S_FIN_RD  = 8'b0100_0000,
    S_FIN_OUT = 8'b1000_0000
  } state_t;

  state_t              state;
  cmd_t                cmd;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    cnt_m1;
  logic [CNT_W-1:0]    cnt_m2;
  logic                full;
  logic                empty;
  logic                flag_under;
  logic                flag_over;
  logic                flag_divz;
  logic [VALUE_W-1:0]  left;
  logic [VALUE_W-1:0]  right;
  logic [VALUE_W-1:0]  acc;
  logic                out_valid;
  logic [VALUE_W-1:0]  out_value;
  logic                out_under;
  logic                out_over;
  logic                out_divz;
  logic                rd_en_hold;
  logic [STACK_AW-1:0] rd_addr;
  logic [VALUE_W-1:0]  rd_data;
  logic                wr_en;
  logic [VALUE_W-1:0]  wr_data;
  logic                div_start;
  logic                div_done;
  logic [VALUE_W-1:0]  div_quo;

  assign cnt_m1    = count - 1'b1;
  assign cnt_m2    = count - 2'd2;
  assign full      = count >= CNT_W'(STACK_DEPTH);
  assign empty     = count == '0;
  assign cmd_ready = state == S_IDLE;

  assign result.valid       = out_valid;
  assign result.value       = out_value;
  assign result.underflow   = out_under;
  assign result.overflow    = out_over;
  assign result.div_by_zero = out_divz;

  always_comb begin
    rd_en_hold = 1'b0;
    rd_addr    = cnt_m1[STACK_AW-1:0];
    wr_en      = 1'b0;
    wr_data    = acc;
    div_start  = 1'b0;
    unique case (state) inside
      S_IDLE: begin
        wr_en   = cmd_valid && cmd_word.kind == KIND_PUSH && !full;
        wr_data = VALUE_W'(cmd_word.digit);
      end
      S_POP_R: rd_addr = cnt_m2[STACK_AW-1:0];
      S_EXEC:  div_start = cmd.op == OP_DIV && right != '0;
      S_PUSH:  wr_en = !full;
      S_FIN_RD, S_FIN_OUT: rd_en_hold = 1'b1;
      default: ;
    endcase
  end

  pfe_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[STACK_AW-1:0]),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pfe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (left),
    .den      (right),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      flag_under <= 1'b0;
      flag_over  <= 1'b0;
      flag_divz  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (result.valid && result.ready && state != S_FIN_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd <= cmd_word;
            unique case (cmd_word.kind)
              KIND_PUSH: begin
                if (full) begin
                  flag_over <= 1'b1;
                end else begin
                  count <= count + 1'b1;
                end
                state <= cmd_word.last ? S_FIN_RD : S_IDLE;
              end
              KIND_OP: state <= S_POP_R;
              default: state <= cmd_word.last ? S_FIN_RD : S_IDLE;
            endcase
          end
        end
        S_POP_R: begin
          if (empty) begin
            flag_under <= 1'b1;
            right      <= EMPTY_VALUE;
          end else begin
            right <= rd_data;
            count <= cnt_m1;
          end
          state <= S_POP_L;
        end
        S_POP_L: begin
          if (empty) begin
            flag_under <= 1'b1;
            left       <= EMPTY_VALUE;
          end else begin
            left  <= rd_data;
            count <= cnt_m1;
          end
          state <= S_EXEC;
        end
        S_EXEC: begin
          state <= div_start ? S_DIV : S_PUSH;
          case (cmd.op)
            OP_ADD: acc <= left + right;
            OP_SUB: acc <= left - right;
            OP_MUL: acc <= left * right;
            default: begin
              if (right == '0) begin
                flag_divz <= 1'b1;
                acc       <= '0;
              end
            end
          endcase
        end
        S_DIV: begin
          if (div_done) begin
            acc   <= div_quo;
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (full) begin
            flag_over <= 1'b1;
          end else begin
            count <= count + 1'b1;
          end
          state <= cmd.last ? S_FIN_RD : S_IDLE;
        end
        S_FIN_RD: begin
          state <= S_FIN_OUT;
        end
        S_FIN_OUT: begin
          if (rd_en_hold && (!out_valid || result.ready)) begin
            out_valid  <= 1'b1;
            out_value  <= empty ? EMPTY_VALUE : rd_data;
            out_under  <= flag_under || empty;
            out_over   <= flag_over;
            out_divz   <= flag_divz;
            count      <= '0;
            flag_under <= 1'b0;
            flag_over  <= 1'b0;
            flag_divz  <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/postfix_expression_evaluator.sv
// Postfix expression evaluator: front end, command queue and stack back end.
// Depends on pfe_pkg, pfe_in_if, pfe_out_if, pfe_front, pfe_queue, pfe_back.
//
// Usage:
//   feed   - one character word per handshake: digits push 0..9, + - * /
//            operate on the top two stack entries, anything else is ignored.
//            Mark the final character of an expression with last.
//   result - one word per expression, after its last character: the popped
//            top of stack (most negative value if empty) and the sticky
//            underflow, overflow and division-by-zero flags of that expression.
// Timing:
//   The front end takes a character every cycle while the queue has room.
//   In the back end a push is written from idle; an operator steps through
//   pop-right, pop-left, execute and push; a non-zero division waits on the
//   bit-serial divider. Final pop and result load follow the last character.
// Reset clears the stack depth, the flags, the queue and the result valid bit;
// stack contents are not cleared. A stalled result holds in the output
// register while the back end keeps working, and the back end waits only
// when the next result is ready to load.
`timescale 1ns / 1ps

module postfix_expression_evaluator (
  input  logic      clk,
  input  logic      rst,
  pfe_in_if.sink    feed,
  pfe_out_if.source result
);
  import pfe_pkg::*;

  logic fq_valid;
  cmd_t fq_word;
  logic fq_ready;
  logic qb_valid;
  cmd_t qb_word;
  logic qb_ready;

  pfe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .feed      (feed),
    .cmd_valid (fq_valid),
    .cmd_word  (fq_word),
    .cmd_ready (fq_ready)
  );

  pfe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_word   (fq_word),
    .in_ready  (fq_ready),
    .out_valid (qb_valid),
    .out_word  (qb_word),
    .out_ready (qb_ready)
  );

  pfe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (qb_valid),
    .cmd_word  (qb_word),
    .cmd_ready (qb_ready),
    .result    (result)
  );

endmodule

FILE: test/pfe_result_checker.sv
// Result checker for the postfix expression evaluator: follows the feed and result channels.
// Predicts each result word from the accepted characters and compares it field by field.
// Depends on pfe_pkg, pfe_in_if and pfe_out_if.
`timescale 1ns / 1ps

module pfe_result_checker (
  input  logic clk,
  input  logic rst,
  pfe_in_if    feed,
  pfe_out_if   result,
  output int   errors,
  output int   pending
);
  import pfe_pkg::*;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               underflow;
    logic               overflow;
    logic               div_by_zero;
  } eval_result_t;

  logic [VALUE_W-1:0] operand_stack [STACK_DEPTH];
  int unsigned        stack_level;
  logic               under_seen;
  logic               over_seen;
  logic               divz_seen;
  eval_result_t       expected_results [$];

  function automatic kind_t char_kind(logic [CHAR_W-1:0] c);
    if (c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_STAR || c == CHAR_SLASH) return KIND_OP;
    if (c >= CHAR_ZERO && c <= CHAR_ZERO + DIGIT_MAX) return KIND_PUSH;
    return KIND_NOP;
  endfunction

  function automatic op_t char_op(logic [CHAR_W-1:0] c);
    if (c == CHAR_PLUS) return OP_ADD;
    if (c == CHAR_MINUS) return OP_SUB;
    if (c == CHAR_STAR) return OP_MUL;
    return OP_DIV;
  endfunction

  function automatic logic [VALUE_W-1:0] pop_operand();
    if (stack_level == 0) begin
      under_seen = 1'b1;
      return EMPTY_VALUE;
    end
    stack_level--;
    return operand_stack[stack_level];
  endfunction

  function automatic void push_operand(logic [VALUE_W-1:0] v);
    if (stack_level >= STACK_DEPTH) begin
      over_seen = 1'b1;
      return;
    end
    operand_stack[stack_level] = v;
    stack_level++;
  endfunction

  function automatic logic [VALUE_W-1:0] quotient_trunc(logic [VALUE_W-1:0] num,
                                                         logic [VALUE_W-1:0] den);
    logic [VALUE_W-1:0] mag_n;
    logic [VALUE_W-1:0] mag_d;
    logic [VALUE_W-1:0] q;
    if (den == '0) begin
      divz_seen = 1'b1;
      return '0;
    end
    mag_n = num[VALUE_W-1] ? ('0 - num) : num;
    mag_d = den[VALUE_W-1] ? ('0 - den) : den;
    q = mag_n / mag_d;
    return (num[VALUE_W-1] != den[VALUE_W-1]) ? ('0 - q) : q;
  endfunction

  always @(posedge clk) begin
    logic [VALUE_W-1:0] lhs;
    logic [VALUE_W-1:0] rhs;
    logic [VALUE_W-1:0] res;
    eval_result_t       want;
    if (rst) begin
      stack_level = 0;
      under_seen  = 1'b0;
      over_seen   = 1'b0;
      divz_seen   = 1'b0;
      expected_results.delete();
      errors = 0;
    end else begin
      if (result.valid && result.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result word: value %0d", $signed(result.value));
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (result.value !== want.value) begin
            $error("value: expected %0d, got %0d", $signed(want.value), $signed(result.value));
            errors++;
          end
          if (result.underflow !== want.underflow) begin
            $error("underflow: expected %0b, got %0b", want.underflow, result.underflow);
            errors++;
          end
          if (result.overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, result.overflow);
            errors++;
          end
          if (result.div_by_zero !== want.div_by_zero) begin
            $error("div_by_zero: expected %0b, got %0b", want.div_by_zero, result.div_by_zero);
            errors++;
          end
        end
      end
      if (feed.valid && feed.ready) begin
        case (char_kind(feed.char_code))
          KIND_OP: begin
            rhs = pop_operand();
            lhs = pop_operand();
            case (char_op(feed.char_code))
              OP_ADD:  res = lhs + rhs;
              OP_SUB:  res = lhs - rhs;
              OP_MUL:  res = lhs * rhs;
              default: res = quotient_trunc(lhs, rhs);
            endcase
            push_operand(res);
          end
          KIND_PUSH: push_operand(VALUE_W'(feed.char_code - CHAR_ZERO));
          default: ;
        endcase
        if (feed.last) begin
          want.value       = pop_operand();
          want.underflow   = under_seen;
          want.overflow    = over_seen;
          want.div_by_zero = divz_seen;
          expected_results.push_back(want);
          stack_level = 0;
          under_seen  = 1'b0;
          over_seen   = 1'b0;
          divz_seen   = 1'b0;
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

FILE: test/tb_postfix_expression_evaluator.sv
// Testbench top for the postfix expression evaluator: clock, reset, stimulus and verdict.
// Drives directed and random postfix expressions; pfe_result_checker predicts and compares.
// Depends on pfe_pkg, pfe_in_if, pfe_out_if, pfe_result_checker and the evaluator RTL.
`timescale 1ns / 1ps

module tb_postfix_expression_evaluator;
  import pfe_pkg::*;

  localparam int PHASE_WORDS = 500;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 200;

  logic clk;
  logic rst;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   words_sent;
  int   stall_cycles;
  int   fail_count;
  int   pending_count;

  pfe_in_if  feed_ch ();
  pfe_out_if result_ch ();

  postfix_expression_evaluator i_dut (
    .clk    (clk),
    .rst    (rst),
    .feed   (feed_ch),
    .result (result_ch)
  );

  pfe_result_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .feed    (feed_ch),
    .result  (result_ch),
    .errors  (fail_count),
    .pending (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    result_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if ((feed_ch.valid && feed_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("postfix_expression_evaluator test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [CHAR_W-1:0] digit_char(int unsigned d);
    return CHAR_ZERO + CHAR_W'(d);
  endfunction

  function automatic logic [CHAR_W-1:0] pick_op();
    case ($urandom_range(0, 3))
      0:       return CHAR_PLUS;
      1:       return CHAR_MINUS;
      2:       return CHAR_STAR;
      default: return CHAR_SLASH;
    endcase
  endfunction

  task automatic send_word(input logic [CHAR_W-1:0] c, input logic l);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      feed_ch.valid <= 1'b0;
      @(posedge clk);
    end
    feed_ch.valid     <= 1'b1;
    feed_ch.char_code <= c;
    feed_ch.last      <= l;
    @(posedge clk);
    while (!feed_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_seq(input logic [CHAR_W-1:0] text [$]);
    for (int i = 0; i < text.size(); i++) begin
      send_word(text[i], i == text.size() - 1);
    end
  endtask

  // Well-formed expression with random content; now and then deep enough to overflow.
  task automatic send_expression();
    logic [CHAR_W-1:0] text [$];
    int level;
    int cap;
    int steps;
    level = 0;
    cap   = ($urandom_range(0, 9) == 0) ? STACK_DEPTH + 4 : STACK_DEPTH;
    steps = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
    repeat (steps) begin
      if (level < 2 || (level < cap && $urandom_range(0, 1) == 1)) begin
        text.push_back(digit_char($urandom_range(0, 9)));
        level++;
      end else begin
        text.push_back(pick_op());
        level--;
      end
      if ($urandom_range(0, 19) == 0) text.push_back(CHAR_W'($urandom_range(0, 255)));
    end
    while (level > 1) begin
      text.push_back(pick_op());
      level--;
    end
    send_seq(text);
  endtask

  task automatic send_broken();
    logic [CHAR_W-1:0] text [$];
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 2))
        0:       text.push_back(digit_char($urandom_range(0, 9)));
        1:       text.push_back(pick_op());
        default: text.push_back(CHAR_W'($urandom_range(0, 255)));
      endcase
    end
    send_seq(text);
  endtask

  // Hold the feed until every expected result word has arrived.
  task automatic drain_results();
    feed_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  initial begin
    logic [CHAR_W-1:0] text [$];
    int tx_pct [3];
    int rx_pct [3];
    int start;
    tx_pct = '{17, 58, 0};
    rx_pct = '{58, 17, 0};
    rst               = 1'b1;
    feed_ch.valid     = 1'b0;
    feed_ch.char_code = '0;
    feed_ch.last      = 1'b0;
    result_ch.ready   = 1'b0;
    stall_cycles      = 0;
    words_sent        = 0;
    tx_idle_pct       = tx_pct[0];
    rx_idle_pct       = rx_pct[0];
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // full stack, dropped push, then multiply
    repeat (STACK_DEPTH + 1) text.push_back(digit_char(9));
    text.push_back(CHAR_STAR);
    send_seq(text);
    // division by zero
    text = {digit_char(5), digit_char(0), CHAR_SLASH};
    send_seq(text);
    // most negative value divided by minus one
    text = {digit_char(0), digit_char(1), CHAR_MINUS, CHAR_SLASH};
    send_seq(text);
    // add on an empty stack
    text = {CHAR_PLUS};
    send_seq(text);
    // ignored code, final pop of an empty stack
    text = {8'hFF};
    send_seq(text);
    drain_results();

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = tx_pct[ph];
      rx_idle_pct <= rx_pct[ph];
      start = words_sent;
      while (words_sent - start < PHASE_WORDS) begin
        if ($urandom_range(0, 4) == 0) send_broken();
        else send_expression();
      end
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("postfix_expression_evaluator test passed");
    end else begin
      $display("postfix_expression_evaluator test failed");
    end
    $finish;
  end

endmodule
